// File: rtl/core/fwra_pkg.sv
// ----------------------------------------------------------------------------
// fwra_pkg: shared types and constants
// Command/status structs between controller and datapath, register indexes,
// and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package fwra_pkg;

   // Configuration register indexes
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 6;
   localparam logic [CsrIndexWidth-1:0] CSR_RADIX       = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DIGIT_COUNT = 2'd1;

   // Register limits and reset values
   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;
   localparam logic [4:0] RADIX_RESET = 5'd10;
   localparam logic [5:0] COUNT_MIN   = 6'd1;
   localparam logic [5:0] COUNT_RESET = 6'd8;

   // ASCII characters
   localparam logic [6:0] ASCII_ZERO = 7'h30;
   localparam logic [6:0] ASCII_A    = 7'h61;
   localparam logic [3:0] DIGIT_NINE = 4'h9;
   localparam logic [3:0] DIGIT_TEN  = 4'ha;

   typedef struct packed {
      logic load;      // capture value and settings, start a run
      logic div_step;  // one restoring-division bit
      logic store;     // write remainder digit, move to next position
      logic rd;        // read digit buffer into output register
      logic rd_next;   // advance read index
   } cmd_type;

   typedef struct packed {
      logic bit_last;  // final bit of the current division
      logic pos_zero;  // digit just divided is the most significant
      logic out_last;  // output register holds the final character
   } status_type;

   function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
      logic [6:0] c;
      if (d <= DIGIT_NINE) begin
         c = ASCII_ZERO + {3'd0, d};
      end else begin
         c = ASCII_A + {3'd0, d - DIGIT_TEN};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/fixed_width_radix_to_ascii.sv
// Operation: each digit takes a full bit-serial division and a buffer write, then each
//   character takes a buffer read and an output handshake, with rsp_ready holding it.
// Throughput: one item at a time; at best the next item is taken the cycle after the
//   last character goes out, and no item is taken while a run is in progress.
// Reset: synchronous, active high; radix returns to 10, digit_count to 8, the
//   sequencer to idle with req_ready high. The digit buffer is not cleared.
// ----------------------------------------------------------------------------
// fixed_width_radix_to_ascii: fixed-width radix-to-ASCII converter
// Converts one unsigned value to digit_count ASCII characters in a
// configurable radix, most significant first, last flag on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_width_radix_to_ascii #(
   parameter int MAX_DIGITS  = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input items
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [VALUE_WIDTH-1:0]               req_value,
   // result items, one per character
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [6:0]                                rsp_ascii_char,
   output logic                                      rsp_last,
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [fwra_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [fwra_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import fwra_pkg::*;

   logic [4:0] radix_ff, radix_in;
   logic [5:0] count_ff, count_in;
   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // Writes must only arrive while idle (the block does not enforce this); csr_ready is tied high
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Drop out-of-range writes and unknown indexes; the register keeps its value
   always_comb begin
      radix_in = radix_ff;
      count_in = count_ff;
      if (csr_write && (csr_index == CSR_RADIX)) begin
         if ((csr_wdata[4:0] >= RADIX_MIN) && (csr_wdata[4:0] <= RADIX_MAX)) begin
            radix_in = csr_wdata[4:0];
         end
      end
      if (csr_write && (csr_index == CSR_DIGIT_COUNT)) begin
         if ((csr_wdata >= COUNT_MIN) && ({1'b0, csr_wdata} <= 7'(MAX_DIGITS))) begin
            count_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         count_ff <= COUNT_RESET;
      end else begin
         radix_ff <= radix_in;
         count_ff <= count_in;
      end
   end

   // Sequencer: divide each digit, store it, then read the buffer out in order
   fwra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Divider, digit buffer and output character register
   fwra_datapath #(
      .MAX_DIGITS  (MAX_DIGITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .value       (req_value),
      .radix       (radix_ff),
      .digit_count (count_ff),
      .cmd         (cmd),
      .status      (status),
      .ascii_char  (rsp_ascii_char),
      .last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/core/fwra_ctrl.sv
// ----------------------------------------------------------------------------
// fwra_ctrl: conversion sequencer
// Steps the datapath through division, digit store and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module fwra_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire fwra_pkg::status_type status,
   output fwra_pkg::cmd_type        cmd
);
   import fwra_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.bit_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.pos_zero ? ST_READ : ST_DIVIDE;
         end
         ST_READ: begin
            cmd.rd       = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (status.out_last) begin
                  req_ready_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/fwra_datapath.sv
// ----------------------------------------------------------------------------
// fwra_datapath: bit-serial divider, digit buffer and output register
// One quotient bit per cycle; remainders land in the digit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module fwra_datapath #(
   parameter int MAX_DIGITS  = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [VALUE_WIDTH-1:0] value,
   input  wire logic [4:0]             radix,
   input  wire logic [5:0]             digit_count,
   input  wire fwra_pkg::cmd_type      cmd,
   output fwra_pkg::status_type        status,
   output logic [6:0]                  ascii_char,
   output logic                        last
);
   import fwra_pkg::*;

   localparam int IdxWidth = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int BitWidth = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] quot_ff;
   logic [3:0]             rem_ff;
   logic [4:0]             radix_ff;
   logic [BitWidth-1:0]    bit_cnt_ff;
   logic [IdxWidth-1:0]    pos_ff;
   logic [IdxWidth-1:0]    last_idx_ff;
   logic [IdxWidth-1:0]    rd_idx_ff;
   logic [3:0]             rd_data_ff;
   logic [3:0]             digit_mem [MAX_DIGITS];

   logic [4:0] rem_shift;
   logic       rem_ge;

   // Restoring division step: remainder stays below the radix, so 4 bits hold it
   assign rem_shift = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign rem_ge    = (rem_shift >= radix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff     <= '0;
         rem_ff      <= 4'd0;
         bit_cnt_ff  <= '0;
         radix_ff    <= RADIX_RESET;
         pos_ff      <= '0;
         last_idx_ff <= '0;
         rd_idx_ff   <= '0;
      end else begin
         if (cmd.load) begin
            quot_ff     <= value;
            rem_ff      <= 4'd0;
            bit_cnt_ff  <= '0;
            radix_ff    <= radix;
            pos_ff      <= IdxWidth'(digit_count - COUNT_MIN);
            last_idx_ff <= IdxWidth'(digit_count - COUNT_MIN);
            rd_idx_ff   <= '0;
         end
         if (cmd.div_step) begin
            quot_ff    <= {quot_ff[VALUE_WIDTH-2:0], rem_ge};
            rem_ff     <= rem_ge ? 4'(rem_shift - radix_ff) : rem_shift[3:0];
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
         end
         if (cmd.store) begin
            rem_ff     <= 4'd0;
            bit_cnt_ff <= '0;
            pos_ff     <= pos_ff - 1'b1;
         end
         if (cmd.rd_next) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   // Digit buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         digit_mem[pos_ff] <= rem_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= digit_mem[rd_idx_ff];
      end
   end

   always_comb begin
      status.bit_last = (bit_cnt_ff == BitWidth'(VALUE_WIDTH - 1));
      status.pos_zero = (pos_ff == '0);
      status.out_last = (rd_idx_ff == last_idx_ff);
   end

   assign ascii_char = digit_to_ascii(rd_data_ff);
   assign last       = status.out_last;

endmodule

`default_nettype wire

// File: rtl/core/fwra_checker.sv
// ----------------------------------------------------------------------------
// fwra_checker: port-level checks for the converter
// Watches the handshakes and character range on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module fwra_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_ascii_char,
   input wire logic       rsp_last
);

   // A stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last))
      else $error("stalled character changed");

   // One item at a time: taking an item closes the input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("input open or output early after accept");

   // No new item while characters go out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open during output");

   // Characters are digits or lowercase a to f
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char >= 7'h30 && rsp_ascii_char <= 7'h39) ||
                    (rsp_ascii_char >= 7'h61 && rsp_ascii_char <= 7'h66))
      else $error("character out of digit range");

   // The input reopens only after the last character is taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_ready) |-> $past(rsp_valid && rsp_ready && rsp_last))
      else $error("input reopened before last character");

endmodule

bind fixed_width_radix_to_ascii fwra_checker u_fwra_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// File: test/tb_fixed_width_radix_to_ascii.sv
// ----------------------------------------------------------------------------
// tb_fixed_width_radix_to_ascii: self-checking bench for the radix converter
// Walks a short table of register writes and values first, then random
// settings and values in bursts. A predictor expands each accepted value into
// its characters and the monitor compares every character and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_width_radix_to_ascii;
   import fwra_pkg::*;

   localparam int MAX_DIGITS      = 32;
   localparam int IDLE_SETTLE     = 4;     // block takes the next item right after a run
   localparam int END_SETTLE      = 50;
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, block backs up
   localparam int STALL_LIMIT     = 6000;  // longer than a full 32-digit run plus the hold-off
   localparam int RANDOM_ITEMS    = 85;
   localparam int DIRECTED_ROWS   = 40;

   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [255:0] NO_TEXT    = '0;

   // register indexes that decode to nothing
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_3 = 2'd3;

   typedef enum logic {ROW_WRITE, ROW_VALUE} row_kind_type;

   // one line of the directed table; text holds the characters typed in by
   // hand, or nothing when the predictor supplies them
   typedef struct packed {
      row_kind_type              kind;
      logic [CsrIndexWidth-1:0]  index;
      logic [CsrDataWidth-1:0]   data;
      logic [31:0]               value;
      logic [255:0]              text;
   } stim_row_type;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [31:0]              req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [6:0]               rsp_ascii_char;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   // predictor state: the two registers as the block should hold them
   logic [4:0] radix_setting = RADIX_RESET;
   logic [5:0] width_setting = COUNT_RESET;

   char_item_type expected_chars [$];
   logic [255:0]  typed_text = '0;
   logic          idle_on = 1'b1;
   logic          hold_off_request = 1'b0;
   int            error_count = 0;
   stim_row_type  directed_rows [0:DIRECTED_ROWS-1];

   fixed_width_radix_to_ascii dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Split the value into width_setting digits of radix_setting, low digit
   // first, keeping only the low digits, and queue them most significant first.
   function automatic void convert_value_to_chars(input logic [31:0] number);
      logic [3:0]    digits [MAX_DIGITS];
      logic [31:0]   quotient;
      char_item_type item;
      int            count;
      count = int'(width_setting);
      quotient = number;
      for (int pos = count - 1; pos >= 0; pos--) begin
         digits[pos] = 4'(quotient % radix_setting);
         quotient = quotient / radix_setting;
      end
      for (int i = 0; i < count; i++) begin
         if (digits[i] < 4'd10) begin
            item.code = CHAR_ZERO + 7'(digits[i]);
         end else begin
            item.code = CHAR_LOWER_A + 7'(digits[i] - 4'd10);
         end
         item.last = (i == count - 1);
         expected_chars.push_back(item);
      end
   endfunction

   function automatic int draw_gap();
      if (idle_on) begin
         return $urandom_range(0, 13);
      end
      return 0;
   endfunction

   // Offer one value; leave valid high after acceptance so that a zero gap
   // carries straight into the next item.
   task automatic offer_value(input logic [31:0] number, input logic [255:0] text);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_value  <= number;
      typed_text = text;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] data);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      repeat (gap) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every queued character, then let the block settle.
   task automatic wait_until_drained(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Result side: draw a stall before each character, and once in the run
   // hold off for a long stretch while the sender keeps offering values.
   initial begin : result_sink
      int gap;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end else begin
            gap = draw_gap();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Monitor: track register writes, predict on every accepted value, and
   // check each accepted character against the oldest expectation.
   always @(posedge clock) begin : scoreboard
      char_item_type want;
      char_item_type typed;
      logic [7:0]    code_byte;
      int            total;
      int            seen;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIX: begin
                  // only the low five bits reach the radix register
                  if (csr_wdata[4:0] >= RADIX_MIN && csr_wdata[4:0] <= RADIX_MAX) begin
                     radix_setting = csr_wdata[4:0];
                  end
               end
               CSR_DIGIT_COUNT: begin
                  if (csr_wdata >= COUNT_MIN && csr_wdata <= 6'(MAX_DIGITS)) begin
                     width_setting = csr_wdata;
                  end
               end
               default: ;  // unknown index, drop the write
            endcase
         end
         if (req_valid && req_ready) begin
            if (typed_text != NO_TEXT) begin
               // expand the hand-typed characters, flag the final one
               total = 0;
               for (int i = 31; i >= 0; i--) begin
                  if (typed_text[i*8 +: 8] != 8'd0) total++;
               end
               seen = 0;
               for (int i = 31; i >= 0; i--) begin
                  code_byte = typed_text[i*8 +: 8];
                  if (code_byte != 8'd0) begin
                     seen++;
                     typed.code = code_byte[6:0];
                     typed.last = (seen == total);
                     expected_chars.push_back(typed);
                  end
               end
            end else begin
               convert_value_to_chars(req_value);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, got %h last %b",
                        $time, rsp_ascii_char, rsp_last);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ascii_char !== want.code) begin
                  $display("%0t: ascii_char mismatch: expected %h, got %h",
                           $time, want.code, rsp_ascii_char);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %b, got %b",
                           $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when no channel moves anything for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog: nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [31:0]             number;
      logic [CsrDataWidth-1:0] data;
      int                      burst;
      int                      phase;
      int                      items_sent;

      // Directed part: reset values, extremes of both registers, every
      // digit character, dropped high digits and ignored register writes.
      directed_rows = '{
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd0,          "00000000"},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd12345678,   "12345678"},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,  "94967295"},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd10, 32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,  "4294967295"},
         '{ROW_WRITE, CSR_RADIX,       6'd16, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd8,  32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'h89AB_CDEF,  "89abcdef"},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'h0123_4567,  "01234567"},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,  "ffffffff"},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd32, 32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,  NO_TEXT},
         '{ROW_WRITE, CSR_RADIX,       6'd2,  32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,
           "11111111111111111111111111111111"},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'h8000_0001,  NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd1,  32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd0,          "0"},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd3,          "1"},
         // radix out of range: keep 2
         '{ROW_WRITE, CSR_RADIX,       6'd17, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_RADIX,       6'd0,  32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_RADIX,       6'd1,  32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd2,          NO_TEXT},
         // digit count out of range and unknown indexes: keep 1
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd0,  32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd33, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd63, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_UNUSED_2,    6'h3f, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_UNUSED_3,    6'h05, 32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd7,          NO_TEXT},
         // top data bit falls outside the radix field: 0x30 reads as 16
         '{ROW_WRITE, CSR_RADIX,       6'h30, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd5,  32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'h0001_2345,  "12345"},
         // base 3 needs 21 digits for all ones; 20 drops the top one
         '{ROW_WRITE, CSR_RADIX,       6'd3,  32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd20, 32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,  NO_TEXT},
         '{ROW_WRITE, CSR_RADIX,       6'd10, 32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd32, 32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'hFFFF_FFFF,  NO_TEXT},
         '{ROW_WRITE, CSR_RADIX,       6'd7,  32'd0,          NO_TEXT},
         '{ROW_WRITE, CSR_DIGIT_COUNT, 6'd12, 32'd0,          NO_TEXT},
         '{ROW_VALUE, CSR_RADIX,       6'd0,  32'd123456789,  NO_TEXT}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            // registers change only with the block idle
            wait_until_drained(IDLE_SETTLE);
            write_register(directed_rows[r].index, directed_rows[r].data);
         end else begin
            offer_value(directed_rows[r].value, directed_rows[r].text);
         end
      end

      // Random part: each phase picks new settings, then sends a burst of
      // values. Most digit counts are small to keep runs short.
      phase = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         wait_until_drained(IDLE_SETTLE);
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 4))
            0:       data = CsrDataWidth'($urandom);
            default: data = CsrDataWidth'($urandom_range(2, 16));
         endcase
         write_register(CSR_RADIX, data);
         case ($urandom_range(0, 9))
            0:       data = CsrDataWidth'(MAX_DIGITS);
            1:       data = CsrDataWidth'($urandom_range(9, 31));
            2:       data = CsrDataWidth'($urandom);
            default: data = CsrDataWidth'($urandom_range(1, 8));
         endcase
         write_register(CSR_DIGIT_COUNT, data);
         if ($urandom_range(0, 5) == 0) begin
            write_register($urandom_range(0, 1) ? CSR_UNUSED_2 : CSR_UNUSED_3,
                           CsrDataWidth'($urandom));
         end
         // once, stall the result side long enough to back the block up
         if (phase == 1) begin
            hold_off_request = 1'b1;
         end
         burst = $urandom_range(6, 14);
         repeat (burst) begin
            case ($urandom_range(0, 3))
               0:       number = $urandom_range(0, 255);
               1:       number = 32'hFFFF_FFFF - $urandom_range(0, 255);
               2:       number = 32'd1 << $urandom_range(0, 31);
               default: number = $urandom;
            endcase
            offer_value(number, NO_TEXT);
            items_sent++;
         end
         phase++;
      end

      wait_until_drained(END_SETTLE);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/core/fwra_pkg.sv
rtl/core/fwra_ctrl.sv
rtl/core/fwra_datapath.sv
rtl/core/fixed_width_radix_to_ascii.sv
rtl/core/fwra_checker.sv
test/tb_fixed_width_radix_to_ascii.sv
